@@ hw/rtl/sine_sample_generator_with_history_assert.svh @@
// Assertion macros for the sine sample generator.
// Each macro expects clk and arst_n in scope.
`ifndef SINE_SAMPLE_GENERATOR_WITH_HISTORY_ASSERT_SVH
`define SINE_SAMPLE_GENERATOR_WITH_HISTORY_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define SSGH_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ssgh assertion failed");

// Next-cycle implication, checked outside of reset.
`define SSGH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ssgh assertion failed");

`endif

@@ hw/rtl/ssgh_pkg.sv @@
package ssgh_pkg;

	// Command codes of an input word.
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// Register indexes on the configuration port (byte address / 4).
	localparam logic [1:0] REG_AMPLITUDE    = 2'd0;
	localparam logic [1:0] REG_PHASE_STEP   = 2'd1;
	localparam logic [1:0] REG_TIME_STEP_NS = 2'd2;

	localparam int PADDR_W  = 4;
	localparam int SAMPLE_W = 16;
	localparam int TIME_W   = 63;
	localparam int PHASE_W  = 32;
	localparam int HIST_AW  = 10;
	localparam int HIST_DEPTH = 1 << HIST_AW;
	localparam int FILL_W   = HIST_AW + 1;
	localparam logic [FILL_W-1:0] FULL_COUNT = FILL_W'(HIST_DEPTH);

	// pi/2 in Q30.
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Taylor divisors (2k)(2k+1) for k = 1..8.
	localparam logic [63:0] TAYLOR_DIV [8] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
	};

	// Quarter-wave sine entry i of a table with 2^abits steps, in Q1.15.
	// Only evaluated at elaboration to build the constant table.
	function automatic logic [15:0] quarter_sine(int unsigned i, int unsigned abits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint sum;
		logic [63:0] r;
		x = (HALF_PI_Q30 * 64'(i)) >> abits;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int k = 0; k < 8; k++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[k];
			if (k % 2 == 0) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		r = (64'(sum) + 64'd16384) >> 15;
		if (r > 64'd32768) begin
			r = 64'd32768;
		end
		return r[15:0];
	endfunction

endpackage

@@ hw/rtl/sine_sample_generator_with_history.sv @@
// Sine sample generator with a sample history ring.
// An accepted word is held in the input register, then in the result register.
// Throughput: one word per cycle unless a held result stalls the pipeline; the input
// register (table read and history read) and the result register are the two registered stages.
// Reset clears the phase, elapsed time, ring pointers and pipeline valids;
// the history memory is not cleared, and only entries below fill_count are read.
`include "sine_sample_generator_with_history_assert.svh"

module sine_sample_generator_with_history #(
	parameter int TABLE_ADDR_BITS = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Command channel.
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             cmd,
	input  logic [ssgh_pkg::HIST_AW-1:0]     read_index,
	// Result channel.
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [ssgh_pkg::SAMPLE_W-1:0] sample,
	output logic [ssgh_pkg::TIME_W-1:0]      time_ns,
	output logic [ssgh_pkg::FILL_W-1:0]      fill_count,
	output logic                             read_ok,
	// Configuration port.
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ssgh_pkg::PADDR_W-1:0]     paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import ssgh_pkg::*;

	localparam int TQ = 1 << TABLE_ADDR_BITS;
	localparam int ROM_AW = TABLE_ADDR_BITS + 1;
	localparam int HIST_W = SAMPLE_W + TIME_W;

	typedef logic [15:0] sine_rom_t [TQ+1];

	function automatic sine_rom_t build_rom();
		sine_rom_t rom;
		for (int unsigned i = 0; i <= TQ; i++) begin
			rom[i] = quarter_sine(i, TABLE_ADDR_BITS);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_rom();

	// Configuration registers.
	logic signed [SAMPLE_W-1:0] amplitude_q;
	logic [31:0]                phase_step_q;
	logic [31:0]                time_step_q;

	// Generator and ring state.
	logic [PHASE_W-1:0] phase_q;
	logic [TIME_W-1:0]  elapsed_q;
	logic [HIST_AW-1:0] oldest_ptr_q;
	logic [FILL_W-1:0]  entry_count_q;

	// Stage 1.
	logic                 valid_s1;
	logic                 tick_s1;
	logic                 ok_s1;
	logic                 neg_s1;
	logic [FILL_W-1:0]    fill_s1;
	logic [15:0]          rom_s1;
	logic [TIME_W-1:0]    time_s1;
	logic [HIST_AW-1:0]   pos_s1;
	logic [HIST_W-1:0]    hist_s1;

	// Stage 2 (result register).
	logic                       valid_s2;
	logic signed [SAMPLE_W-1:0] sample_s2;
	logic [TIME_W-1:0]          time_s2;
	logic [FILL_W-1:0]          fill_s2;
	logic                       ok_s2;

	logic [HIST_W-1:0] hist_mem [HIST_DEPTH];

	logic en;
	logic accept;
	logic is_tick;
	logic is_full;
	logic cfg_wr;

	// The pipeline moves whenever the result register is free or being taken.
	assign en       = !valid_s2 || out_ready;
	assign in_ready = en;
	assign accept   = in_valid && en;
	assign is_tick  = (cmd == CMD_TICK);
	assign is_full  = (entry_count_q == FULL_COUNT);

	// Configuration writes and reads.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q  <= 16'sd256;
			phase_step_q <= 32'd4294967;
			time_step_q  <= 32'd1000000;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_AMPLITUDE:    amplitude_q  <= pwdata[SAMPLE_W-1:0];
				REG_PHASE_STEP:   phase_step_q <= pwdata;
				REG_TIME_STEP_NS: time_step_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_AMPLITUDE:    prdata = {{(32-SAMPLE_W){amplitude_q[SAMPLE_W-1]}}, amplitude_q};
			REG_PHASE_STEP:   prdata = phase_step_q;
			REG_TIME_STEP_NS: prdata = time_step_q;
			default:          prdata = '0;
		endcase
	end

	// Table address from the top phase bits; odd quadrants run backwards.
	logic [1:0]                 quad;
	logic [TABLE_ADDR_BITS-1:0] tab_addr;
	logic [ROM_AW-1:0]          rom_idx;

	assign quad     = phase_q[PHASE_W-1 -: 2];
	assign tab_addr = phase_q[PHASE_W-3 -: TABLE_ADDR_BITS];
	assign rom_idx  = quad[0] ? (ROM_AW'(TQ) - {1'b0, tab_addr}) : {1'b0, tab_addr};

	// Ring positions for a new sample and for a read.
	logic [HIST_AW-1:0] wr_pos;
	logic [HIST_AW-1:0] rd_pos;
	logic               rd_hit;

	assign wr_pos = is_full ? oldest_ptr_q : (oldest_ptr_q + entry_count_q[HIST_AW-1:0]);
	assign rd_pos = oldest_ptr_q + read_index;
	assign rd_hit = (FILL_W'(read_index) < entry_count_q);

	// Advance the generator and the ring on every accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= '0;
			elapsed_q     <= '0;
			oldest_ptr_q  <= '0;
			entry_count_q <= '0;
		end else if (accept && is_tick) begin
			phase_q   <= phase_q + phase_step_q;
			elapsed_q <= elapsed_q + TIME_W'(time_step_q);
			if (is_full) begin
				oldest_ptr_q <= oldest_ptr_q + 1'b1;
			end else begin
				entry_count_q <= entry_count_q + 1'b1;
			end
		end
	end

	// Scale the table value by the amplitude, round half up, saturate.
	logic signed [16:0]         sine_val;
	logic signed [32:0]         prod;
	logic signed [17:0]         rnd;
	logic signed [SAMPLE_W-1:0] gen_sample;
	logic [HIST_W-1:0]          wr_data;

	assign sine_val   = neg_s1 ? -$signed({1'b0, rom_s1}) : $signed({1'b0, rom_s1});
	assign prod       = amplitude_q * sine_val;
	assign rnd        = 18'((prod + 33'sd16384) >>> 15);
	assign gen_sample = (rnd > 18'sd32767) ? 16'sd32767 : rnd[SAMPLE_W-1:0];
	assign wr_data    = {gen_sample, time_s1};

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage 1 payload, table read and history read.
	always_ff @(posedge clk) begin
		if (en) begin
			tick_s1 <= is_tick;
			ok_s1   <= is_tick || rd_hit;
			neg_s1  <= quad[1];
			fill_s1 <= (is_tick && !is_full) ? entry_count_q + 1'b1 : entry_count_q;
			time_s1 <= elapsed_q;
			pos_s1  <= wr_pos;
			rom_s1  <= SINE_ROM[rom_idx];
		end
	end

	// History memory: the sample in stage 1 is written as it leaves, and a read
	// of that same entry in the same cycle takes the new word directly.
	always_ff @(posedge clk) begin
		if (en && valid_s1 && tick_s1) begin
			hist_mem[pos_s1] <= wr_data;
		end
		if (en) begin
			if (valid_s1 && tick_s1 && (pos_s1 == rd_pos)) begin
				hist_s1 <= wr_data;
			end else begin
				hist_s1 <= hist_mem[rd_pos];
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fill_s2 <= fill_s1;
			ok_s2   <= ok_s1;
			if (tick_s1) begin
				sample_s2 <= gen_sample;
				time_s2   <= time_s1;
			end else if (ok_s1) begin
				sample_s2 <= hist_s1[HIST_W-1 -: SAMPLE_W];
				time_s2   <= hist_s1[TIME_W-1:0];
			end else begin
				sample_s2 <= '0;
				time_s2   <= '0;
			end
		end
	end

	assign out_valid  = valid_s2;
	assign sample     = sample_s2;
	assign time_ns    = time_s2;
	assign fill_count = fill_s2;
	assign read_ok    = ok_s2;

	// Checks.
	`SSGH_ASSERT_IMPL(a_fill_bound, 1'b1, entry_count_q <= FULL_COUNT)
	`SSGH_ASSERT_IMPL(a_oldest_until_full, !is_full, oldest_ptr_q == '0)
	`SSGH_ASSERT_NEXT(a_fill_grows, accept && is_tick && !is_full, entry_count_q == $past(entry_count_q) + 1'b1)
	`SSGH_ASSERT_IMPL(a_miss_zero, out_valid && !read_ok, sample == '0 && time_ns == '0)

endmodule

@@ tb/sine_sample_generator_with_history_checker.sv @@
module sine_sample_generator_with_history_checker
	import ssgh_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic                       cmd,
	input  logic [HIST_AW-1:0]         read_index,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [TIME_W-1:0]          time_ns,
	input  logic [FILL_W-1:0]          fill_count,
	input  logic                       read_ok,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [PADDR_W-1:0]         paddr,
	input  logic [31:0]                pwdata,
	input  logic                       end_of_test,
	output int unsigned                failures
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_BITS = 10;
	localparam int QUARTER_STEPS = 1 << TABLE_BITS;
	localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
	localparam int PRINT_LIMIT = 40;

	typedef struct {
		logic [SAMPLE_W-1:0] smp;
		logic [TIME_W-1:0]   stamp;
		logic [FILL_W-1:0]   fill;
		logic                ok;
	} sample_word_t;

	// Quarter-wave sine table in Q1.15 and the mirrored generator state.
	int unsigned sine_q15 [0:QUARTER_STEPS];
	logic signed [15:0] amp_reg;
	logic [31:0] phase_step_reg;
	logic [31:0] time_step_reg;
	logic [PHASE_W-1:0] phase;
	logic [TIME_W-1:0] elapsed;
	logic [SAMPLE_W-1:0] ring_sample [HIST_DEPTH];
	logic [TIME_W-1:0] ring_stamp [HIST_DEPTH];
	logic [HIST_AW-1:0] oldest;
	logic [FILL_W-1:0] held;
	sample_word_t words_due [$];
	int unsigned mismatch_total = 0;
	bit end_seen = 1'b0;

	assign failures = mismatch_total;

	// One table entry: Taylor series of sin() in Q30, rounded to Q15 and capped at 1.0.
	function automatic int unsigned quarter_wave(int unsigned i);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned r;
		longint acc;
		x = (PI_HALF_Q30 * longint'(i)) >> TABLE_BITS;
		x2 = (x * x) >> 30;
		term = x;
		acc = longint'(x);
		for (int unsigned k = 1; k <= 8; k++) begin
			term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) begin
				acc -= longint'(term);
			end else begin
				acc += longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		r = (longint'(acc) + 64'd16384) >> 15;
		if (r > 64'd32768) begin
			r = 64'd32768;
		end
		return int'(r);
	endfunction

	initial begin
		for (int i = 0; i <= QUARTER_STEPS; i++) begin
			sine_q15[i] = quarter_wave(i);
		end
	end

	// Phase to sine by quadrant folding, then amplitude scaling rounded half up
	// and clamped to the 16-bit range.
	function automatic logic [SAMPLE_W-1:0] scaled_sine(logic [PHASE_W-1:0] ph,
			logic signed [15:0] amp);
		logic [1:0] quad;
		int unsigned a;
		int unsigned idx;
		longint s;
		longint prod;
		longint r;
		quad = ph[PHASE_W-1 -: 2];
		a = ph[PHASE_W-3 -: TABLE_BITS];
		idx = quad[0] ? QUARTER_STEPS - a : a;
		s = longint'(sine_q15[idx]);
		if (quad[1]) begin
			s = -s;
		end
		prod = longint'(amp) * s;
		r = ((prod + 64'sd1073741824 + 64'sd16384) >>> 15) - 64'sd32768;
		if (r > 32767) begin
			r = 32767;
		end
		if (r < -32768) begin
			r = -32768;
		end
		return r[SAMPLE_W-1:0];
	endfunction

	task automatic report(string msg);
		if (mismatch_total < PRINT_LIMIT) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
		mismatch_total++;
	endtask

	// A tick makes a sample and pushes it into the ring; a read looks one up.
	task automatic apply_command(logic c, logic [HIST_AW-1:0] idx);
		sample_word_t w;
		logic [HIST_AW-1:0] pos;
		if (c == CMD_TICK) begin
			w.smp = scaled_sine(phase, amp_reg);
			if (held == FULL_COUNT) begin
				pos = oldest;
				oldest = oldest + 1'b1;
			end else begin
				pos = oldest + held[HIST_AW-1:0];
				held = held + 1'b1;
			end
			ring_sample[pos] = w.smp;
			ring_stamp[pos] = elapsed;
			w.stamp = elapsed;
			w.fill = held;
			w.ok = 1'b1;
			phase = phase + phase_step_reg;
			elapsed = elapsed + TIME_W'(time_step_reg);
		end else if (FILL_W'(idx) < held) begin
			pos = oldest + idx;
			w.smp = ring_sample[pos];
			w.stamp = ring_stamp[pos];
			w.fill = held;
			w.ok = 1'b1;
		end else begin
			w.smp = '0;
			w.stamp = '0;
			w.fill = held;
			w.ok = 1'b0;
		end
		words_due = {words_due, w};
	endtask

	// Compare one accepted result word with the oldest prediction.
	task automatic check_word();
		sample_word_t w;
		if (words_due.size() == 0) begin
			report($sformatf("result word with nothing pending: sample %0d time %0d",
				sample, time_ns));
		end else begin
			w = words_due[0];
			words_due.delete(0);
			if (sample !== w.smp) begin
				report($sformatf("sample got %h want %h", sample, w.smp));
			end
			if (time_ns !== w.stamp) begin
				report($sformatf("time_ns got %0d want %0d", time_ns, w.stamp));
			end
			if (fill_count !== w.fill) begin
				report($sformatf("fill_count got %0d want %0d", fill_count, w.fill));
			end
			if (read_ok !== w.ok) begin
				report($sformatf("read_ok got %b want %b", read_ok, w.ok));
			end
		end
	endtask

	// Watch both channels and the register port on every edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_reg = 16'sd256;
			phase_step_reg = 32'd4294967;
			time_step_reg = 32'd1000000;
			phase = '0;
			elapsed = '0;
			oldest = '0;
			held = '0;
			words_due.delete();
		end else begin
			if (out_valid && out_ready) begin
				check_word();
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_AMPLITUDE: amp_reg = pwdata[15:0];
					REG_PHASE_STEP: phase_step_reg = pwdata;
					REG_TIME_STEP_NS: time_step_reg = pwdata;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				apply_command(cmd, read_index);
			end
			if (end_of_test && !end_seen) begin
				end_seen = 1'b1;
				if (words_due.size() != 0) begin
					report($sformatf("%0d result words never arrived", words_due.size()));
				end
			end
		end
	end

endmodule

@@ tb/sine_sample_generator_with_history_tb.sv @@
module sine_sample_generator_with_history_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ssgh_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 8;
	localparam int WORDS_PER_PHASE = 500;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic cmd;
	logic [HIST_AW-1:0] read_index;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] sample;
	logic [TIME_W-1:0] time_ns;
	logic [FILL_W-1:0] fill_count;
	logic read_ok;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic end_of_test;
	int unsigned failures;

	longint unsigned words_in = 0;
	longint unsigned words_out = 0;
	int unsigned quiet_cycles = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int ticks_sent = 0;

	always #2 clk = ~clk;

	sine_sample_generator_with_history uut (.*);

	sine_sample_generator_with_history_checker checker_i (.*);

	// Receiver side: random back-pressure at the current stall rate.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// Word counts for draining, and a watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			words_in <= words_in + 1;
		end
		if (out_valid && out_ready) begin
			words_out <= words_out + 1;
		end
		if (psel || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("sine_sample_generator_with_history verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one command word, with random gaps in front, and hold it until taken.
	task automatic send_word(logic c, logic [HIST_AW-1:0] idx);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		read_index <= idx;
		if (c == CMD_TICK) begin
			ticks_sent++;
		end
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Mostly ticks; half the reads aim inside the filled part of the ring.
	task automatic send_random();
		logic c;
		logic [HIST_AW-1:0] idx;
		int filled;
		c = ($urandom_range(99) < 65) ? CMD_TICK : CMD_READ;
		filled = (ticks_sent < HIST_DEPTH) ? ticks_sent : HIST_DEPTH;
		if (filled > 0 && $urandom_range(1) == 1) begin
			idx = HIST_AW'($urandom_range(filled - 1));
		end else begin
			idx = HIST_AW'($urandom);
		end
		send_word(c, idx);
	endtask

	// Setup then access phase, then psel and penable drop before anything else.
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Stop sending and wait until every word sent has come back.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_out != words_in) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		in_valid = 1'b0;
		cmd = CMD_TICK;
		read_index = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		end_of_test = 1'b0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reads of an empty history come back empty.
		send_word(CMD_READ, '0);
		send_word(CMD_READ, '1);
		settle();

		// Quarter-turn steps land on every quadrant boundary, including the
		// negative full-scale point where the sample clamps.
		write_reg(REG_AMPLITUDE, 32'hFFFF_8000);
		write_reg(REG_PHASE_STEP, 32'h4000_0000);
		write_reg(REG_TIME_STEP_NS, 32'hFFFF_FFFF);
		repeat (5) send_word(CMD_TICK, '0);
		send_word(CMD_READ, '0);
		send_word(CMD_READ, 10'd4);
		send_word(CMD_READ, 10'd5);
		send_word(CMD_READ, '1);
		settle();

		// Largest amplitude with phase and time frozen.
		write_reg(REG_AMPLITUDE, 32'h0000_7FFF);
		write_reg(REG_PHASE_STEP, 32'h0000_0000);
		write_reg(REG_TIME_STEP_NS, 32'h0000_0000);
		repeat (3) send_word(CMD_TICK, '1);
		send_word(CMD_READ, 10'd7);
		send_word(CMD_READ, 10'd8);

		// Random phases, each with its own settings and idling pattern.
		for (int p = 0; p < 4; p++) begin
			settle();
			case (p)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 70;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 70;
				end
				default: begin
					sender_idle_pct = 31;
					receiver_stall_pct = 31;
				end
			endcase
			if (p == 1) begin
				write_reg(REG_AMPLITUDE, 32'hFFFF_FFFF);
				write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
				write_reg(REG_TIME_STEP_NS, 32'h0000_0001);
			end else begin
				write_reg(REG_AMPLITUDE, $urandom);
				write_reg(REG_PHASE_STEP, $urandom);
				write_reg(REG_TIME_STEP_NS, $urandom);
			end
			repeat (WORDS_PER_PHASE) send_random();
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		end_of_test <= 1'b1;
		@(posedge clk);
		@(posedge clk);
		if (failures == 0) begin
			$display("sine_sample_generator_with_history verification clean");
		end else begin
			$display("sine_sample_generator_with_history verification failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/ssgh_pkg.sv
hw/rtl/sine_sample_generator_with_history.sv
tb/sine_sample_generator_with_history_checker.sv
tb/sine_sample_generator_with_history_tb.sv
